// ===== sv/bpb_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and control types of the breath pressure baseline block
package bpb_pkg;

  localparam int RAW_BITS_DEF       = 19;
  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam int GAIN_W = 16;
  localparam int LEN_W  = 16;
  localparam int CNT_W  = 17;
  localparam int OUT_W  = 28;

  localparam logic [LEN_W-1:0]  CAL_RESET_COUNT = 16'd20;
  localparam logic [GAIN_W-1:0] GAIN_RESET      = 16'd256;
  localparam logic [OUT_W-1:0]  PRESSURE_MAX    = 28'hFFF_FFFF;

  // input opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_RECAL  = 1'b1;

  // configuration register indexes
  localparam logic REG_SENSOR_OFFSET = 1'b0;
  localparam logic REG_GAIN_Q8       = 1'b1;

  typedef struct packed {
    logic load_sample;
    logic recal;
    logic cal_acc;
    logic diff;
    logic mul;
    logic sat;
    logic div_start;
    logic div_take;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic cal_active;
    logic cal_last;
    logic div_done;
  } dp_status_t;

endpackage

// ===== sv/breath_pressure_baseline_top.sv =====
`timescale 1ns / 1ps
// top level of the breath pressure baseline removal block
//
// Takes raw pressure sensor words and recalibrate commands, one at a time.
// Each sample has sensor_offset subtracted. While calibrating (21 samples after
// reset, recal_length+1 after a recalibrate command) the samples are summed and
// counted and each gives a word with pressure_valid low; the last one divides
// the sum by the count (truncating toward zero) into the baseline and raises
// calibrate_done. Afterwards each sample gives ((sample - baseline) * gain_q8)
// >> GAIN_FRAC_BITS, clamped at zero and saturating at the 28-bit maximum.
// Sequencing: a recalibrate command is taken at acceptance and gives no word.
// An ordinary sample passes through the SAMPLE, MUL, SAT and EMIT states from
// acceptance to the next acceptance, its output word registered on leaving EMIT;
// a calibration sample passes through SAMPLE and EMIT, and the final calibration
// sample through SAMPLE, DSTART, DWAIT and EMIT, waiting in DWAIT for
// the serial divider that produces one quotient bit per cycle over the
// RAW_BITS + 18 bit (37-bit at the default) sum. in_stall is high while a
// word is in flight. A finished word sits in the output register and
// the next item is already accepted while it waits.
module breath_pressure_baseline_top #(
  parameter int RAW_BITS       = bpb_pkg::RAW_BITS_DEF,
  parameter int GAIN_FRAC_BITS = bpb_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  // configuration write port
  input  logic                                         cfg_we,
  input  logic                                         cfg_index,
  input  logic [((RAW_BITS > 16) ? RAW_BITS : 16)-1:0] cfg_data,
  // input channel
  input  logic                                         in_valid,
  output logic                                         in_stall,
  input  logic                                         opcode,
  input  logic [RAW_BITS-1:0]                          raw_sample,
  input  logic [bpb_pkg::LEN_W-1:0]                    recal_length,
  // output channel
  output logic                                         out_valid,
  input  logic                                         out_stall,
  output logic [bpb_pkg::OUT_W-1:0]                    pressure,
  output logic                                         pressure_valid,
  output logic                                         calibrate_done
);

  import bpb_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing: accept, accumulate or scale, divide at the end of calibration
  bpb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // arithmetic, state and the output word register
  bpb_dp #(
    .RAW_BITS       (RAW_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .raw_sample     (raw_sample),
    .recal_length   (recal_length),
    .pressure       (pressure),
    .pressure_valid (pressure_valid),
    .calibrate_done (calibrate_done)
  );

  // a calibration word never carries a valid pressure
  a_done_not_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(pressure_valid && calibrate_done))
    else $error("calibrate_done together with pressure_valid");

  // a calibration word reports zero pressure
  a_cal_word_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pressure_valid) |-> (pressure == '0))
    else $error("nonzero pressure on a calibration word");

  // a recalibrate command completes at acceptance and leaves the input open
  a_recal_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && opcode == OP_RECAL) |=> !in_stall)
    else $error("recalibrate command held the input");

  // the divider only finishes while the controller waits for it
  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> in_stall)
    else $error("divider finished outside a calibration end");

endmodule

// ===== sv/bpb_div.sv =====
`timescale 1ns / 1ps
// restoring unsigned divider, one quotient bit per cycle
module bpb_div #(
  parameter int DVD_W = 37,
  parameter int DVS_W = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CW = $clog2(DVD_W);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DVD_W-1:0] acc;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   rem_sh;
  logic             ge;

  assign rem_sh   = {rem, acc[DVD_W-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= ge ? DVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[DVS_W-1:0];
        acc <= {acc[DVD_W-2:0], ge};
        cnt <= CW'(cnt + 1'b1);
        if (cnt == CW'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/bpb_dp.sv =====
`timescale 1ns / 1ps
// datapath: config registers, calibration accumulator, baseline, gain and output word
module bpb_dp #(
  parameter int RAW_BITS       = bpb_pkg::RAW_BITS_DEF,
  parameter int GAIN_FRAC_BITS = bpb_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  bpb_pkg::dp_cmd_t                                     cmd,
  output bpb_pkg::dp_status_t                                  status,
  input  logic                                                 cfg_we,
  input  logic                                                 cfg_index,
  input  logic [((RAW_BITS > 16) ? RAW_BITS : 16)-1:0]         cfg_data,
  input  logic [RAW_BITS-1:0]                                  raw_sample,
  input  logic [bpb_pkg::LEN_W-1:0]                            recal_length,
  output logic [bpb_pkg::OUT_W-1:0]                            pressure,
  output logic                                                 pressure_valid,
  output logic                                                 calibrate_done
);

  import bpb_pkg::*;

  localparam int SMP_W  = RAW_BITS + 1;
  localparam int SUM_W  = SMP_W + CNT_W;
  localparam int BASE_W = RAW_BITS + 2;
  localparam int DIFF_W = BASE_W + 1;
  localparam int PROD_W = SMP_W + GAIN_W;
  localparam int CMP_W  = (PROD_W > OUT_W) ? PROD_W : OUT_W;

  logic [RAW_BITS-1:0] sensor_offset;
  logic [GAIN_W-1:0]   gain_q8;

  logic [SMP_W-1:0]  sample_r;
  logic              cal_active;
  logic [LEN_W-1:0]  cal_countdown;
  logic [SUM_W-1:0]  cal_sum;
  logic [CNT_W-1:0]  cal_count;
  logic [BASE_W-1:0] baseline;
  logic [DIFF_W-1:0] diff_r;
  logic [PROD_W-1:0] prod_r;
  logic              div_neg;

  logic [OUT_W-1:0] res_pressure;
  logic             res_valid;
  logic             res_done;

  logic [SUM_W-1:0]  sum_mag;
  logic [SUM_W-1:0]  quo;
  logic              div_done;
  logic [BASE_W-1:0] quo_low;
  logic              diff_pos;
  logic [CMP_W-1:0]  shifted;

  assign sum_mag  = cal_sum[SUM_W-1] ? SUM_W'(~cal_sum + SUM_W'(1)) : cal_sum;
  assign quo_low  = quo[BASE_W-1:0];
  assign diff_pos = !diff_r[DIFF_W-1] && (diff_r != '0);
  assign shifted  = CMP_W'(prod_r) >> GAIN_FRAC_BITS;

  bpb_div #(
    .DVD_W(SUM_W),
    .DVS_W(CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum_mag),
    .divisor  (cal_count),
    .done     (div_done),
    .quotient (quo)
  );

  assign status.cal_active = cal_active;
  assign status.cal_last   = (cal_countdown == '0);
  assign status.div_done   = div_done;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_offset <= '0;
      gain_q8       <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SENSOR_OFFSET: sensor_offset <= cfg_data[RAW_BITS-1:0];
        REG_GAIN_Q8:       gain_q8       <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // calibration state
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_active    <= 1'b1;
      cal_countdown <= CAL_RESET_COUNT;
      cal_sum       <= '0;
      cal_count     <= '0;
      baseline      <= '1;
    end else begin
      if (cmd.recal) begin
        cal_active    <= 1'b1;
        cal_countdown <= recal_length;
        cal_sum       <= '0;
        cal_count     <= '0;
      end
      if (cmd.cal_acc) begin
        cal_sum   <= cal_sum + {{(SUM_W-SMP_W){sample_r[SMP_W-1]}}, sample_r};
        cal_count <= CNT_W'(cal_count + 1'b1);
        if (cal_countdown == '0) begin
          cal_active <= 1'b0;
        end else begin
          cal_countdown <= LEN_W'(cal_countdown - 1'b1);
        end
      end
      if (cmd.div_take) begin
        baseline <= div_neg ? BASE_W'(~quo_low + BASE_W'(1)) : quo_low;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      sample_r <= {1'b0, raw_sample} - {1'b0, sensor_offset};
    end
    if (cmd.diff) begin
      diff_r <= {{2{sample_r[SMP_W-1]}}, sample_r} - {baseline[BASE_W-1], baseline};
    end
    if (cmd.mul) begin
      prod_r <= diff_pos ? PROD_W'(diff_r[SMP_W-1:0]) * PROD_W'(gain_q8) : '0;
    end
    if (cmd.div_start) begin
      div_neg <= cal_sum[SUM_W-1];
    end
    if (cmd.cal_acc) begin
      res_pressure <= '0;
      res_valid    <= 1'b0;
      res_done     <= 1'b0;
    end
    if (cmd.div_take) begin
      res_pressure <= '0;
      res_valid    <= 1'b0;
      res_done     <= 1'b1;
    end
    if (cmd.sat) begin
      res_pressure <= (shifted > CMP_W'(PRESSURE_MAX)) ? PRESSURE_MAX : shifted[OUT_W-1:0];
      res_valid    <= 1'b1;
      res_done     <= 1'b0;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pressure       <= res_pressure;
      pressure_valid <= res_valid;
      calibrate_done <= res_done;
    end
  end

endmodule

// ===== sv/bpb_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine: input handshake, sequencing and output valid
module bpb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                opcode,
  input  logic                out_stall,
  input  bpb_pkg::dp_status_t status,
  output logic                in_stall,
  output logic                out_valid,
  output bpb_pkg::dp_cmd_t    cmd
);

  import bpb_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SAMPLE = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_SAT    = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DWAIT  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (opcode == OP_RECAL) begin
            cmd.recal = 1'b1;
          end else begin
            cmd.load_sample = 1'b1;
            state_next      = S_SAMPLE;
          end
        end
      end
      S_SAMPLE: begin
        if (status.cal_active) begin
          cmd.cal_acc = 1'b1;
          state_next  = status.cal_last ? S_DSTART : S_EMIT;
        end else begin
          cmd.diff   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SAT;
      end
      S_SAT: begin
        cmd.sat    = 1'b1;
        state_next = S_EMIT;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DWAIT;
      end
      S_DWAIT: begin
        if (status.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid || !out_stall) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for the breath pressure baseline block: directed table, then random phases
module tb;
  import bpb_pkg::*;

  localparam int RAW_W    = RAW_BITS_DEF;
  localparam int CFG_W    = (RAW_W > GAIN_W) ? RAW_W : GAIN_W;
  localparam int FRAC_W   = GAIN_FRAC_BITS_DEF;
  localparam int RAW_TOP  = (1 << RAW_W) - 1;
  // slowest word is the final calibration sample behind the serial divider
  localparam int DRAIN_CYCLES  = 48;
  localparam int RANDOM_ITEMS  = 1900;

  // one output word as the block reports it
  typedef struct packed {
    logic [OUT_W-1:0] pressure;
    logic             pressure_valid;
    logic             calibrate_done;
  } press_word_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  // directed row: either an input word repeated reps times or a register write;
  // typed rows carry the expected word, the others go through the tracker
  typedef struct packed {
    row_kind_t        kind;
    logic [7:0]       reps;
    logic             op;
    logic [RAW_W-1:0] raw;
    logic [LEN_W-1:0] len;
    logic             reg_idx;
    logic [CFG_W-1:0] reg_val;
    logic             typed;
    press_word_t      want;
  } dir_row_t;

  localparam int DIR_ROWS = 28;

  // the directed table, walked once after reset
  dir_row_t dir_rows [DIR_ROWS] = '{
    // reset calibration: 21 samples, flat input gives a baseline of 1000
    '{ROW_WORD, 8'd20, OP_SAMPLE, 19'd1000, 16'd0, REG_SENSOR_OFFSET, 19'd0, 1'b1,
      '{28'd0, 1'b0, 1'b0}},
    '{ROW_WORD, 8'd1, OP_SAMPLE, 19'd1000, 16'd0, REG_SENSOR_OFFSET, 19'd0, 1'b1,
      '{28'd0, 1'b0, 1'b1}},
    // at the baseline, just above it, below it (clamped), top of the raw range
    '{ROW_WORD, 8'd1, OP_SAMPLE, 19'd1000, 16'd0, REG_SENSOR_OFFSET, 19'd0, 1'b1,
      '{28'd0, 1'b1, 1'b0}},
    '{ROW_WORD, 8'd1, OP_SAMPLE, 19'd1256, 16'd0, REG_SENSOR_OFFSET, 19'd0, 1'b1,
      '{28'd256, 1'b1, 1'b0}},
    '{ROW_WORD, 8'd1, OP_SAMPLE, 19'd0, 16'd0, REG_SENSOR_OFFSET, 19'd0, 1'b1,
      '{28'd0, 1'b1, 1'b0}},
    '{ROW_WORD, 8'd1, OP_SAMPLE, 19'h7FFFF, 16'd0, REG_SENSOR_OFFSET, 19'd0, 1'b1,
      '{28'd523287, 1'b1, 1'b0}},
    // maximum offset, one-sample calibration on raw zero: most negative baseline
    '{ROW_CFG, 8'd1, OP_SAMPLE, 19'd0, 16'd0, REG_SENSOR_OFFSET, 19'h7FFFF, 1'b0,
      '{28'd0, 1'b0, 1'b0}},
    '{ROW_WORD, 8'd1, OP_RECAL, 19'd0, 16'd0, REG_SENSOR_OFFSET, 19'd0, 1'b0,
      '{28'd0, 1'b0, 1'b0}},
    '{ROW_WORD, 8'd1, OP_SAMPLE, 19'd0, 16'd0, REG_SENSOR_OFFSET, 19'd0, 1'b1,
      '{28'd0, 1'b0, 1'b1}},
    '{ROW_WORD, 8'd1, OP_SAMPLE, 19'h7FFFF, 16'd0, REG_SENSOR_OFFSET, 19'd0, 1'b1,
      '{28'd524287, 1'b1, 1'b0}},
    // zero offset and full gain against that baseline: largest pressure the block can make
    '{ROW_CFG, 8'd1, OP_SAMPLE, 19'd0, 16'd0, REG_SENSOR_OFFSET, 19'd0, 1'b0,
      '{28'd0, 1'b0, 1'b0}},
    '{ROW_CFG, 8'd1, OP_SAMPLE, 19'd0, 16'd0, REG_GAIN_Q8, 19'h0FFFF, 1'b0,
      '{28'd0, 1'b0, 1'b0}},
    '{ROW_WORD, 8'd1, OP_SAMPLE, 19'h7FFFF, 16'hFFFF, REG_SENSOR_OFFSET, 19'd0, 1'b0,
      '{28'd0, 1'b0, 1'b0}},
    '{ROW_WORD, 8'd1, OP_SAMPLE, 19'd1, 16'd0, REG_SENSOR_OFFSET, 19'd0, 1'b0,
      '{28'd0, 1'b0, 1'b0}},
    // zero gain wipes everything
    '{ROW_CFG, 8'd1, OP_SAMPLE, 19'd0, 16'd0, REG_GAIN_Q8, 19'd0, 1'b0,
      '{28'd0, 1'b0, 1'b0}},
    '{ROW_WORD, 8'd1, OP_SAMPLE, 19'h7FFFF, 16'd0, REG_SENSOR_OFFSET, 19'd0, 1'b1,
      '{28'd0, 1'b1, 1'b0}},
    // gain 1.5 with junk above bit 15, offset above the coming samples
    '{ROW_CFG, 8'd1, OP_SAMPLE, 19'd0, 16'd0, REG_GAIN_Q8, 19'h70180, 1'b0,
      '{28'd0, 1'b0, 1'b0}},
    '{ROW_CFG, 8'd1, OP_SAMPLE, 19'd0, 16'd0, REG_SENSOR_OFFSET, 19'd1000, 1'b0,
      '{28'd0, 1'b0, 1'b0}},
    // longest calibration, cut short by a new recalibrate
    '{ROW_WORD, 8'd1, OP_RECAL, 19'h7FFFF, 16'hFFFF, REG_SENSOR_OFFSET, 19'd0, 1'b0,
      '{28'd0, 1'b0, 1'b0}},
    '{ROW_WORD, 8'd1, OP_SAMPLE, 19'd5, 16'd0, REG_SENSOR_OFFSET, 19'd0, 1'b1,
      '{28'd0, 1'b0, 1'b0}},
    '{ROW_WORD, 8'd1, OP_SAMPLE, 19'd7, 16'd0, REG_SENSOR_OFFSET, 19'd0, 1'b1,
      '{28'd0, 1'b0, 1'b0}},
    '{ROW_WORD, 8'd1, OP_RECAL, 19'd0, 16'd2, REG_SENSOR_OFFSET, 19'd0, 1'b0,
      '{28'd0, 1'b0, 1'b0}},
    // negative samples: sum -2987 over 3 truncates to a baseline of -995
    '{ROW_WORD, 8'd1, OP_SAMPLE, 19'd0, 16'd0, REG_SENSOR_OFFSET, 19'd0, 1'b1,
      '{28'd0, 1'b0, 1'b0}},
    '{ROW_WORD, 8'd1, OP_SAMPLE, 19'd10, 16'd0, REG_SENSOR_OFFSET, 19'd0, 1'b1,
      '{28'd0, 1'b0, 1'b0}},
    '{ROW_WORD, 8'd1, OP_SAMPLE, 19'd3, 16'd0, REG_SENSOR_OFFSET, 19'd0, 1'b1,
      '{28'd0, 1'b0, 1'b1}},
    // exactly at a truncated baseline: a floored one would give 1 here
    '{ROW_WORD, 8'd1, OP_SAMPLE, 19'd5, 16'd0, REG_SENSOR_OFFSET, 19'd0, 1'b1,
      '{28'd0, 1'b1, 1'b0}},
    '{ROW_WORD, 8'd1, OP_SAMPLE, 19'd1000, 16'd0, REG_SENSOR_OFFSET, 19'd0, 1'b0,
      '{28'd0, 1'b0, 1'b0}},
    '{ROW_WORD, 8'd1, OP_SAMPLE, 19'd6, 16'd0, REG_SENSOR_OFFSET, 19'd0, 1'b0,
      '{28'd0, 1'b0, 1'b0}}
  };

  // block ports, all known from time zero
  logic               clk;
  logic               rst          = 1'b1;
  logic               cfg_we       = 1'b0;
  logic               cfg_index    = REG_SENSOR_OFFSET;
  logic [CFG_W-1:0]   cfg_data     = '0;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic               opcode       = OP_SAMPLE;
  logic [RAW_W-1:0]   raw_sample   = '0;
  logic [LEN_W-1:0]   recal_length = '0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic [OUT_W-1:0]   pressure;
  logic               pressure_valid;
  logic               calibrate_done;

  breath_pressure_baseline_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .raw_sample     (raw_sample),
    .recal_length   (recal_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pressure       (pressure),
    .pressure_valid (pressure_valid),
    .calibrate_done (calibrate_done)
  );

  // baseline tracker: the bench's own copy of registers and calibration state
  logic [RAW_W-1:0]    trk_offset;
  logic [GAIN_W-1:0]   trk_gain;
  logic signed [17:0]  trk_countdown;   // negative once calibration is over
  logic signed [37:0]  trk_sum;
  logic [CNT_W-1:0]    trk_count;
  logic signed [20:0]  trk_baseline;

  press_word_t pressure_due_q [$];     // words still owed by the block
  int          mism_cnt    = 0;
  int          items_taken = 0;
  int          stall_left  = 0;
  bit          quiet       = 1'b0;     // no gaps on either side during this phase

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // work out the word an accepted item causes; returns 0 for a recalibrate
  function automatic bit track_word(input logic op, input logic [RAW_W-1:0] raw,
                                    input logic [LEN_W-1:0] len, output press_word_t w);
    longint smp;
    longint dif;
    longint scaled;
    w = '0;
    if (op == OP_RECAL) begin
      trk_sum       = '0;
      trk_count     = '0;
      trk_countdown = signed'({2'b00, len});
      return 1'b0;
    end
    // offset sample stays signed, may go below zero
    smp = longint'(raw) - longint'(trk_offset);
    if (trk_countdown >= 0) begin
      trk_sum   = 38'(trk_sum + smp);
      trk_count = trk_count + 1'b1;
      if (trk_countdown == 0) begin
        // signed division truncates toward zero
        trk_baseline     = 21'(longint'(trk_sum) / longint'(trk_count));
        w.calibrate_done = 1'b1;
      end
      trk_countdown = trk_countdown - 1'b1;
      return 1'b1;
    end
    dif = smp - longint'(trk_baseline);
    if (dif <= 0) begin
      scaled = 0;
    end else begin
      scaled = (dif * longint'(trk_gain)) >>> FRAC_W;
      if (scaled > longint'(PRESSURE_MAX)) scaled = longint'(PRESSURE_MAX);
    end
    w.pressure       = scaled[OUT_W-1:0];
    w.pressure_valid = 1'b1;
    return 1'b1;
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  // raw reading: mostly near the current level, sometimes anywhere or at the rails
  function automatic logic [RAW_W-1:0] pick_raw(input int level);
    int v;
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = RAW_TOP;
      2, 3:    v = $urandom_range(0, RAW_TOP);
      default: v = level + $urandom_range(0, 1200) - 600;
    endcase
    if (v < 0) v = 0;
    if (v > RAW_TOP) v = RAW_TOP;
    return v[RAW_W-1:0];
  endfunction

  // send one word and hold it until taken; tracker runs at the accepting edge
  task automatic send_word(input logic op, input logic [RAW_W-1:0] raw,
                           input logic [LEN_W-1:0] len, input logic typed,
                           input press_word_t want);
    press_word_t w;
    int          gap;
    in_valid     <= 1'b1;
    opcode       <= op;
    raw_sample   <= raw;
    recal_length <= len;
    do @(posedge clk); while (in_stall);
    items_taken++;
    if (track_word(op, raw, len, w)) pressure_due_q.push_back(typed ? want : w);
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid, wait for every owed word, then let the divider finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pressure_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write, only called while the block is idle
  task automatic cfg_write(input logic idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_SENSOR_OFFSET) trk_offset = val[RAW_W-1:0];
    else trk_gain = val[GAIN_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random stall stretches
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = idle_len();
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // every taken output word against the oldest owed one
  always @(posedge clk) begin
    press_word_t got_w;
    press_word_t due_w;
    if (!rst && out_valid && !out_stall) begin
      got_w = {pressure, pressure_valid, calibrate_done};
      if (pressure_due_q.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= 10)
          $display("unexpected word: pressure %0d valid %b done %b",
                   got_w.pressure, got_w.pressure_valid, got_w.calibrate_done);
      end else begin
        due_w = pressure_due_q.pop_front();
        if (got_w.pressure !== due_w.pressure ||
            got_w.pressure_valid !== due_w.pressure_valid ||
            got_w.calibrate_done !== due_w.calibrate_done) begin
          mism_cnt++;
          if (mism_cnt <= 10)
            $display("mismatch at %0t: pressure %0d/%0d valid %b/%b done %b/%b (exp/act)",
                     $realtime, due_w.pressure, got_w.pressure, due_w.pressure_valid,
                     got_w.pressure_valid, due_w.calibrate_done, got_w.calibrate_done);
        end
      end
    end
  end

  // hard stop well past the slowest legal run
  initial begin
    #(1_500_000 * 8);
    $display("breath_pressure_baseline_top regression: fail");
    $finish;
  end

  // stimulus
  initial begin
    int          level;
    int          burst;
    int          first_random;
    logic [15:0] gain_pick;
    trk_offset    = '0;
    trk_gain      = GAIN_RESET;
    trk_countdown = signed'({2'b00, CAL_RESET_COUNT});
    trk_sum       = '0;
    trk_count     = '0;
    trk_baseline  = -21'sd1;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        settle();
        cfg_write(dir_rows[r].reg_idx, dir_rows[r].reg_val);
      end else begin
        repeat (dir_rows[r].reps)
          send_word(dir_rows[r].op, dir_rows[r].raw, dir_rows[r].len,
                    dir_rows[r].typed, dir_rows[r].want);
      end
    end

    // random phases: new settings now and then, usually a recalibration, then a run of samples
    first_random = items_taken;
    while (items_taken - first_random < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 4))
          0:       cfg_write(REG_SENSOR_OFFSET, '0);
          1:       cfg_write(REG_SENSOR_OFFSET, CFG_W'(RAW_TOP));
          default: cfg_write(REG_SENSOR_OFFSET, CFG_W'($urandom_range(0, RAW_TOP)));
        endcase
      end
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       gain_pick = '0;
          1:       gain_pick = 16'hFFFF;
          2:       gain_pick = GAIN_RESET;
          default: gain_pick = 16'($urandom_range(0, 16'hFFFF));
        endcase
        // bits above the gain width are don't-care
        cfg_write(REG_GAIN_Q8, {3'($urandom_range(0, 7)), gain_pick});
      end
      quiet = ($urandom_range(0, 4) == 0);
      level = $urandom_range(0, RAW_TOP);

      // abandoned calibration of any length, always followed by a short one
      if ($urandom_range(0, 5) == 0) begin
        send_word(OP_RECAL, RAW_W'($urandom), LEN_W'($urandom), 1'b0, '0);
        repeat ($urandom_range(0, 4))
          send_word(OP_SAMPLE, pick_raw(level), LEN_W'($urandom), 1'b0, '0);
        send_word(OP_RECAL, RAW_W'($urandom), LEN_W'($urandom_range(0, 6)), 1'b0, '0);
      end else if ($urandom_range(0, 4) != 0) begin
        send_word(OP_RECAL, RAW_W'($urandom),
                  LEN_W'(($urandom_range(0, 7) == 0) ? $urandom_range(7, 40)
                                                     : $urandom_range(0, 6)),
                  1'b0, '0);
      end

      burst = $urandom_range(8, 50);
      repeat (burst) begin
        // occasional recalibrate in the middle of measuring
        if ($urandom_range(0, 40) == 0)
          send_word(OP_RECAL, RAW_W'($urandom), LEN_W'($urandom_range(0, 6)), 1'b0, '0);
        else
          send_word(OP_SAMPLE, pick_raw(level), LEN_W'($urandom), 1'b0, '0);
      end
    end

    settle();
    if (mism_cnt == 0 && pressure_due_q.size() == 0) begin
      $display("breath_pressure_baseline_top regression: pass");
    end else begin
      $display("breath_pressure_baseline_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/bpb_pkg.sv
sv/bpb_div.sv
sv/bpb_dp.sv
sv/bpb_ctrl.sv
sv/breath_pressure_baseline_top.sv
sim/tb.sv
